/* hdl/tdcth_pkg.sv */
// ----------------------------------------------------------------------------
// tdcth_pkg
// Types and constants shared by the TDC time-over-threshold hit builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tdcth_pkg;

   localparam int unsigned TIME_W       = 25;
   localparam int unsigned COARSE_PS_W  = 24;
   localparam int unsigned CORR_NUM_W   = 19;
   localparam int unsigned CORR_RECIP_W = 21;
   localparam int unsigned CORR_W       = 14;
   localparam int unsigned PROD_W       = CORR_NUM_W + CORR_RECIP_W;

   localparam logic [2:0]  KIND_TIME     = 3'b100;
   localparam logic [9:0]  FINE_LOW      = 10'd31;
   localparam logic [23:0] PS_PER_COARSE = 24'd5000;

   // round(d * 5000 / 460) = floor((500 * d + 23) / 46), divide by 46 as
   // multiply by reciprocal; exact for every numerator below 2^19
   localparam logic [18:0] CORR_SCALE   = 19'd500;
   localparam logic [18:0] CORR_BIAS    = 19'd23;
   localparam logic [20:0] CORR_RECIP   = 21'd1458889;
   localparam int unsigned CORR_SHIFT   = 26;

   localparam logic [15:0] TAG_RESET     = 16'hBEEF;
   localparam logic [6:0]  LEFT_RESET    = 7'd2;
   localparam logic [6:0]  RIGHT_RESET   = 7'd18;
   localparam logic [23:0] MIN_RESET     = 24'd1000;

   localparam logic [1:0] REG_HEADER_TAG    = 2'd0;
   localparam logic [1:0] REG_LEFT_CHANNEL  = 2'd1;
   localparam logic [1:0] REG_RIGHT_CHANNEL = 2'd2;
   localparam logic [1:0] REG_MIN_VALUE     = 2'd3;

   typedef struct packed {
      logic [15:0] header_tag;
      logic [6:0]  left_channel;
      logic [6:0]  right_channel;
      logic [23:0] min_value;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic upd_left;
      logic upd_right;
      logic rising;
      logic finish;
   } ctl_type;

   typedef struct packed {
      ctl_type                   ctl;
      logic signed [TIME_W-1:0]  time_ps;
   } entry_type;

endpackage

`default_nettype wire

/* hdl/tdcth_front.sv */
// ----------------------------------------------------------------------------
// tdcth_front
// Header seek, word classification and three-stage time decode.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcth_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [31:0]           req_data_word,
   input  wire logic                  req_subevent_end,
   input  wire tdcth_pkg::cfg_type    cfg,
   input  wire logic                  q_full,
   output logic                       push,
   output tdcth_pkg::entry_type       push_entry
);

   logic        in_block_ff, in_block_in;
   logic [15:0] words_left_ff, words_left_in;

   logic                              s1_valid_ff, s1_valid_in;
   tdcth_pkg::ctl_type                s1_ctl_ff, s1_ctl_in;
   logic [tdcth_pkg::CORR_NUM_W-1:0]  s1_num_ff, s1_num_in;
   logic [tdcth_pkg::COARSE_PS_W-1:0] s1_cps_ff, s1_cps_in;

   logic                              s2_valid_ff, s2_valid_in;
   tdcth_pkg::ctl_type                s2_ctl_ff, s2_ctl_in;
   logic [tdcth_pkg::CORR_W-1:0]      s2_corr_ff, s2_corr_in;
   logic [tdcth_pkg::COARSE_PS_W-1:0] s2_cps_ff, s2_cps_in;

   logic                              s3_valid_ff, s3_valid_in;
   tdcth_pkg::entry_type              s3_entry_ff, s3_entry_in;

   logic                              adv;
   logic                              accept;
   logic                              emit0;
   tdcth_pkg::ctl_type                ctl0;
   logic                              is_time;
   logic [6:0]                        chan;
   logic [9:0]                        fine;
   logic [9:0]                        fine_d;
   logic [15:0]                       wl_dec;
   logic [tdcth_pkg::PROD_W-1:0]      prod;

   // the whole pipe moves together; hold only when the last stage cannot push
   assign adv       = !s3_valid_ff || !q_full;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign push      = s3_valid_ff && !q_full;
   assign push_entry = s3_entry_ff;

   always_comb begin
      is_time = req_data_word[31:29] == tdcth_pkg::KIND_TIME;
      chan    = req_data_word[28:22];
      wl_dec  = words_left_ff - 16'd1;
      in_block_in   = in_block_ff;
      words_left_in = words_left_ff;
      ctl0  = '0;
      emit0 = 1'b0;
      if (accept) begin
         if (!in_block_ff) begin
            if (req_data_word[15:0] == cfg.header_tag) begin
               ctl0.clear    = 1'b1;
               ctl0.finish   = (req_data_word[31:16] == 16'd0) || req_subevent_end;
               emit0         = 1'b1;
               in_block_in   = !ctl0.finish;
               words_left_in = ctl0.finish ? 16'd0 : req_data_word[31:16];
            end
         end else begin
            ctl0.upd_left  = is_time && (chan == cfg.left_channel);
            ctl0.upd_right = is_time && (chan == cfg.right_channel);
            ctl0.rising    = req_data_word[11];
            ctl0.finish    = (wl_dec == 16'd0) || req_subevent_end;
            // words that touch nothing and close nothing are dropped here
            emit0          = ctl0.upd_left || ctl0.upd_right || ctl0.finish;
            in_block_in    = !ctl0.finish;
            words_left_in  = ctl0.finish ? 16'd0 : wl_dec;
         end
      end
   end

   always_comb begin
      fine   = req_data_word[21:12];
      fine_d = (fine > tdcth_pkg::FINE_LOW) ? (fine - tdcth_pkg::FINE_LOW) : 10'd0;
      s1_valid_in = adv ? emit0 : s1_valid_ff;
      s1_ctl_in   = adv ? ctl0 : s1_ctl_ff;
      s1_num_in   = adv ? (tdcth_pkg::CORR_NUM_W'(fine_d) * tdcth_pkg::CORR_SCALE
                           + tdcth_pkg::CORR_BIAS)
                        : s1_num_ff;
      s1_cps_in   = adv ? (tdcth_pkg::COARSE_PS_W'(req_data_word[10:0])
                           * tdcth_pkg::PS_PER_COARSE)
                        : s1_cps_ff;
   end

   always_comb begin
      prod = {{tdcth_pkg::CORR_RECIP_W{1'b0}}, s1_num_ff}
             * {{tdcth_pkg::CORR_NUM_W{1'b0}}, tdcth_pkg::CORR_RECIP};
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
      s2_ctl_in   = adv ? s1_ctl_ff : s2_ctl_ff;
      s2_corr_in  = adv ? prod[tdcth_pkg::CORR_SHIFT +: tdcth_pkg::CORR_W] : s2_corr_ff;
      s2_cps_in   = adv ? s1_cps_ff : s2_cps_ff;
   end

   always_comb begin
      s3_valid_in = adv ? s2_valid_ff : s3_valid_ff;
      s3_entry_in = s3_entry_ff;
      if (adv) begin
         s3_entry_in.ctl     = s2_ctl_ff;
         s3_entry_in.time_ps = $signed({1'b0, s2_cps_ff})
                               - $signed({{(tdcth_pkg::TIME_W - tdcth_pkg::CORR_W){1'b0}},
                                          s2_corr_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff   <= 1'b0;
         words_left_ff <= 16'd0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
      end else begin
         in_block_ff   <= in_block_in;
         words_left_ff <= words_left_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         s3_valid_ff   <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff   <= s1_ctl_in;
      s1_num_ff   <= s1_num_in;
      s1_cps_ff   <= s1_cps_in;
      s2_ctl_ff   <= s2_ctl_in;
      s2_corr_ff  <= s2_corr_in;
      s2_cps_ff   <= s2_cps_in;
      s3_entry_ff <= s3_entry_in;
   end

endmodule

`default_nettype wire

/* hdl/tdcth_queue.sv */
// ----------------------------------------------------------------------------
// tdcth_queue
// Small register queue between the decode front and the tracking back.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcth_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire tdcth_pkg::entry_type  push_entry,
   input  wire logic                  pop,
   output tdcth_pkg::entry_type       head,
   output logic                       q_full,
   output logic                       q_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tdcth_pkg::entry_type store [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_full  = count_ff == CNT_W'(DEPTH);
   assign q_empty = count_ff == '0;
   assign head    = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* hdl/tdcth_back.sv */
// ----------------------------------------------------------------------------
// tdcth_back
// Rising/falling edge tracking, threshold test and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcth_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tdcth_pkg::entry_type         head,
   input  wire logic                         q_empty,
   output logic                              pop,
   input  wire logic [23:0]                  min_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [tdcth_pkg::TIME_W-1:0] rsp_time_left,
   output logic signed [tdcth_pkg::TIME_W-1:0] rsp_tot_left,
   output logic signed [tdcth_pkg::TIME_W-1:0] rsp_time_right,
   output logic signed [tdcth_pkg::TIME_W-1:0] rsp_tot_right
);

   localparam int unsigned W = tdcth_pkg::TIME_W;

   logic signed [W-1:0] rise_l_ff, rise_l_in, over_l_ff, over_l_in;
   logic signed [W-1:0] rise_r_ff, rise_r_in, over_r_ff, over_r_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] out_rise_l_ff, out_over_l_ff, out_rise_r_ff, out_over_r_ff;
   logic signed [W-1:0] base_rise_l, base_over_l, base_rise_r, base_over_r;
   logic signed [W-1:0] th;
   logic                hit;

   // a closing word needs the result register free; others drain at once
   assign pop = !q_empty && (!head.ctl.finish || !rsp_valid_ff || rsp_ready);
   assign th  = $signed({1'b0, min_value});

   always_comb begin
      base_rise_l = head.ctl.clear ? '0 : rise_l_ff;
      base_over_l = head.ctl.clear ? '0 : over_l_ff;
      base_rise_r = head.ctl.clear ? '0 : rise_r_ff;
      base_over_r = head.ctl.clear ? '0 : over_r_ff;
      rise_l_in = base_rise_l;
      over_l_in = base_over_l;
      rise_r_in = base_rise_r;
      over_r_in = base_over_r;
      if (head.ctl.upd_left) begin
         if (head.ctl.rising) begin
            rise_l_in = head.time_ps;
         end else if (base_rise_l > 0) begin
            over_l_in = head.time_ps - base_rise_l;
            rise_l_in = '0;
         end
      end
      if (head.ctl.upd_right) begin
         if (head.ctl.rising) begin
            rise_r_in = head.time_ps;
         end else if (base_rise_r > 0) begin
            over_r_in = head.time_ps - base_rise_r;
            rise_r_in = '0;
         end
      end
      hit = head.ctl.finish && (rise_l_in > th) && (over_l_in > th)
            && (rise_r_in > th) && (over_r_in > th);
      rsp_valid_in = (pop && hit) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_l_ff    <= '0;
         over_l_ff    <= '0;
         rise_r_ff    <= '0;
         over_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            rise_l_ff <= rise_l_in;
            over_l_ff <= over_l_in;
            rise_r_ff <= rise_r_in;
            over_r_ff <= over_r_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && hit) begin
         out_rise_l_ff <= rise_l_in;
         out_over_l_ff <= over_l_in;
         out_rise_r_ff <= rise_r_in;
         out_over_r_ff <= over_r_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_time_left  = out_rise_l_ff;
   assign rsp_tot_left   = out_over_l_ff;
   assign rsp_time_right = out_rise_r_ff;
   assign rsp_tot_right  = out_over_r_ff;

endmodule

`default_nettype wire

/* hdl/tdc_word_tot_hit_builder.sv */
// ----------------------------------------------------------------------------
// tdc_word_tot_hit_builder
// Builds left/right time-over-threshold hits from a stream of TDC words.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | req_valid/req_ready | data_word[31:0], subevent_end
//  rsp_     | out       | rsp_valid/rsp_ready | time_left, tot_left, time_right,
//           |           |                     | tot_right (25-bit signed, ps)
//  csr_     | in        | csr_valid/csr_ready | index[1:0], data[23:0]
//
//  One word per cycle sustained while req_ready stays high. A hit shows on
//  rsp_ after the word that closes its block passes three decode stages (the
//  reciprocal multiply sets the depth), a queue write, then the result register.
//  Synchronous reset clears all control state and the tracked times; the
//  configuration returns to its reset values. csr_ready is always high.
//  A stall on rsp_ holds only closing words; once the queue fills and the
//  last decode stage is occupied, req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_word_tot_hit_builder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic        req_subevent_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [24:0] rsp_time_left,
   output logic signed [24:0] rsp_tot_left,
   output logic signed [24:0] rsp_time_right,
   output logic signed [24:0] rsp_tot_right,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   tdcth_pkg::cfg_type   cfg_ff, cfg_in;
   logic                 q_full, q_empty, push, pop;
   tdcth_pkg::entry_type push_entry, head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tdcth_pkg::REG_HEADER_TAG:    cfg_in.header_tag    = csr_data[15:0];
            tdcth_pkg::REG_LEFT_CHANNEL:  cfg_in.left_channel  = csr_data[6:0];
            tdcth_pkg::REG_RIGHT_CHANNEL: cfg_in.right_channel = csr_data[6:0];
            tdcth_pkg::REG_MIN_VALUE:     cfg_in.min_value     = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_tag    <= tdcth_pkg::TAG_RESET;
         cfg_ff.left_channel  <= tdcth_pkg::LEFT_RESET;
         cfg_ff.right_channel <= tdcth_pkg::RIGHT_RESET;
         cfg_ff.min_value     <= tdcth_pkg::MIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tdcth_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_word    (req_data_word),
      .req_subevent_end (req_subevent_end),
      .cfg              (cfg_ff),
      .q_full           (q_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   tdcth_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_full     (q_full),
      .q_empty    (q_empty)
   );

   tdcth_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .pop            (pop),
      .min_value      (cfg_ff.min_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_time_left  (rsp_time_left),
      .rsp_tot_left   (rsp_tot_left),
      .rsp_time_right (rsp_time_right),
      .rsp_tot_right  (rsp_tot_right)
   );

endmodule

`default_nettype wire

/* hdl/tdcth_checker.sv */
// ----------------------------------------------------------------------------
// tdcth_checker
// Port-level checks on the hit builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcth_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [31:0] req_data_word,
   input wire logic        req_subevent_end,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic signed [24:0] rsp_time_left,
   input wire logic signed [24:0] rsp_tot_left,
   input wire logic signed [24:0] rsp_time_right,
   input wire logic signed [24:0] rsp_tot_right,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [1:0]  csr_index,
   input wire logic [23:0] csr_data
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_time_left)
         && $stable(rsp_tot_left) && $stable(rsp_time_right) && $stable(rsp_tot_right))
      else $error("result word changed while stalled");

   // after reset: nothing pending, input open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipe not empty after reset");

   // a hit passes a non-negative threshold on all four values
   a_hit_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_time_left > 25'sd0 && rsp_tot_left > 25'sd0
         && rsp_time_right > 25'sd0 && rsp_tot_right > 25'sd0)
      else $error("hit with non-positive value");

   // rising times never exceed the largest coarse count
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_time_left <= 25'sd10235000 && rsp_time_right <= 25'sd10235000)
      else $error("rising time out of range");

endmodule

bind tdc_word_tot_hit_builder tdcth_checker u_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TDC time-over-threshold hit builder.
// Words go in through a queued driver with random gaps. Each accepted word
// updates an in-bench copy of the block state. Every hit that copy predicts
// is compared field by field with what the block delivers, under several
// register settings, random back-pressure and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam int FINE_TOP      = 491;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [31:0] word;
      logic        sub_end;
   } payload_word_type;

   typedef struct packed {
      logic [24:0] time_left;
      logic [24:0] tot_left;
      logic [24:0] time_right;
      logic [24:0] tot_right;
   } tot_hit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic [31:0] req_data_word = '0;
   logic        req_subevent_end = 1'b0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire  [24:0] rsp_time_left;
   wire  [24:0] rsp_tot_left;
   wire  [24:0] rsp_time_right;
   wire  [24:0] rsp_tot_right;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [1:0]  csr_index = tdcth_pkg::REG_HEADER_TAG;
   logic [23:0] csr_data = '0;

   tdc_word_tot_hit_builder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_word    (req_data_word),
      .req_subevent_end (req_subevent_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_time_left    (rsp_time_left),
      .rsp_tot_left     (rsp_tot_left),
      .rsp_time_right   (rsp_time_right),
      .rsp_tot_right    (rsp_tot_right),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   payload_word_type words_pending[$];
   tot_hit_type      hits_due[$];

   // in-bench copy of the block state
   tdcth_pkg::cfg_type cfg_now;
   logic        in_blk;
   logic [15:0] words_rem;
   int          rise_l, tot_l, rise_r, tot_r;

   int words_queued = 0;
   int words_taken = 0;
   int blocks_closed = 0;
   int hits_seen = 0;
   int mismatches = 0;
   int settings_applied = 0;
   int quiet_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   int hold_asked = 0;
   int hold_granted = 0;
   logic send_idle = 1'b1;
   logic recv_idle = 1'b1;

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic int word_time_ps(logic [31:0] w);
      int coarse, fine, d, span;
      coarse = int'(w[10:0]);
      fine   = int'(w[21:12]);
      span   = FINE_TOP - int'(tdcth_pkg::FINE_LOW);
      d      = (fine > int'(tdcth_pkg::FINE_LOW)) ? fine - int'(tdcth_pkg::FINE_LOW) : 0;
      return coarse * int'(tdcth_pkg::PS_PER_COARSE)
             - (d * int'(tdcth_pkg::PS_PER_COARSE) + span / 2) / span;
   endfunction

   function automatic logic [31:0] time_word(logic [6:0] ch, logic rising, int coarse,
                                             int fine);
      return {tdcth_pkg::KIND_TIME, ch, fine[9:0], rising, coarse[10:0]};
   endfunction

   // something that is not part of a clean rise/fall pattern
   function automatic logic [31:0] stray_word();
      int r;
      r = $urandom_range(2);
      if (r == 0) return $urandom;
      if (r == 1) return time_word(7'($urandom), 1'($urandom), $urandom_range(2047),
                                   $urandom_range(1023));
      return {3'b011, 29'($urandom)};
   endfunction

   task automatic track_edge(input logic rising, input int t, inout int rise, inout int over);
      if (rising) begin
         rise = t;
      end else if (rise > 0) begin
         over = t - rise;
         rise = 0;
      end
   endtask

   task automatic apply_word(input logic [31:0] w, input logic sub_end);
      logic        closing;
      int          t, th;
      tot_hit_type hit;
      closing = 1'b0;
      if (!in_blk) begin
         if (w[15:0] == cfg_now.header_tag) begin
            in_blk    = 1'b1;
            words_rem = w[31:16];
            rise_l = 0; tot_l = 0; rise_r = 0; tot_r = 0;
            closing = (words_rem == 16'd0) || sub_end;
         end
      end else begin
         if (w[31:29] == tdcth_pkg::KIND_TIME) begin
            t = word_time_ps(w);
            if (w[28:22] == cfg_now.left_channel) track_edge(w[11], t, rise_l, tot_l);
            if (w[28:22] == cfg_now.right_channel) track_edge(w[11], t, rise_r, tot_r);
         end
         words_rem = words_rem - 16'd1;
         closing = (words_rem == 16'd0) || sub_end;
      end
      if (closing) begin
         in_blk    = 1'b0;
         words_rem = 16'd0;
         blocks_closed++;
         th = int'(cfg_now.min_value);
         if (rise_l > th && rise_r > th && tot_l > th && tot_r > th) begin
            hit.time_left  = 25'(rise_l);
            hit.tot_left   = 25'(tot_l);
            hit.time_right = 25'(rise_r);
            hit.tot_right  = 25'(tot_r);
            hits_due.insert(hits_due.size(), hit);
         end
      end
   endtask

   // word driver: take the next pending word once the slot is free
   always @(posedge clock) begin : drive_words
      payload_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         in_blk    = 1'b0;
         words_rem = 16'd0;
         rise_l = 0; tot_l = 0; rise_r = 0; tot_r = 0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_word(req_data_word, req_subevent_end);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (words_pending.size() > 0) begin
               nxt = words_pending.pop_front();
               req_valid        <= 1'b1;
               req_data_word    <= nxt.word;
               req_subevent_end <= nxt.sub_end;
               send_gap = send_idle ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic note_failure(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("hit %0d: %s", hits_seen, msg);
   endtask

   // hit monitor and receiver stalls
   always @(posedge clock) begin : check_hits
      tot_hit_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            hits_seen++;
            if (hits_due.size() == 0) begin
               note_failure($sformatf("unexpected hit %0d %0d %0d %0d",
                  $signed(rsp_time_left), $signed(rsp_tot_left),
                  $signed(rsp_time_right), $signed(rsp_tot_right)));
            end else begin
               want = hits_due.pop_front();
               if (rsp_time_left !== want.time_left)
                  note_failure($sformatf("time_left expected %0d got %0d",
                     $signed(want.time_left), $signed(rsp_time_left)));
               if (rsp_tot_left !== want.tot_left)
                  note_failure($sformatf("tot_left expected %0d got %0d",
                     $signed(want.tot_left), $signed(rsp_tot_left)));
               if (rsp_time_right !== want.time_right)
                  note_failure($sformatf("time_right expected %0d got %0d",
                     $signed(want.time_right), $signed(rsp_time_right)));
               if (rsp_tot_right !== want.tot_right)
                  note_failure($sformatf("tot_right expected %0d got %0d",
                     $signed(want.tot_right), $signed(rsp_tot_right)));
            end
         end
         if (hold_granted != hold_asked) begin
            hold_granted = hold_asked;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (recv_idle && $urandom_range(3) == 0) recv_gap = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : watch_progress
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, %0d hits still due", QUIET_LIMIT,
                     hits_due.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic offer(input logic [31:0] w, input logic sub_end);
      payload_word_type it;
      it.word    = w;
      it.sub_end = sub_end;
      words_pending.insert(words_pending.size(), it);
      words_queued++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         tdcth_pkg::REG_HEADER_TAG:    cfg_now.header_tag    = val[15:0];
         tdcth_pkg::REG_LEFT_CHANNEL:  cfg_now.left_channel  = val[6:0];
         tdcth_pkg::REG_RIGHT_CHANNEL: cfg_now.right_channel = val[6:0];
         tdcth_pkg::REG_MIN_VALUE:     cfg_now.min_value     = val;
         default: ;
      endcase
   endtask

   // junk in the unused upper bits must be dropped
   task automatic set_config(input logic [15:0] tag, input logic [6:0] left,
                             input logic [6:0] right, input logic [23:0] min_ps);
      write_reg(tdcth_pkg::REG_HEADER_TAG, {8'($urandom), tag});
      write_reg(tdcth_pkg::REG_LEFT_CHANNEL, {17'($urandom), left});
      write_reg(tdcth_pkg::REG_RIGHT_CHANNEL, {17'($urandom), right});
      write_reg(tdcth_pkg::REG_MIN_VALUE, min_ps);
      settings_applied++;
   endtask

   task automatic begin_phase(input logic send, input logic recv);
      @(negedge clock);
      send_idle = send;
      recv_idle = recv;
   endtask

   // wait until every word is taken and every hit is in, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      while (words_taken != words_queued || hits_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_block();
      logic [31:0] edges[2][3];
      logic [31:0] body[$];
      logic [15:0] len;
      logic [6:0]  ch;
      logic        hdr_end;
      int          kind, cut, c0, il, ir;
      for (int s = 0; s < 2; s++) begin
         ch = s ? cfg_now.right_channel : cfg_now.left_channel;
         c0 = $urandom_range(1800);
         edges[s][0] = time_word(ch, 1'b1, c0, $urandom_range(1023));
         edges[s][1] = time_word(ch, 1'b0, c0 + $urandom_range(200), $urandom_range(1023));
         edges[s][2] = time_word(ch, 1'b1, $urandom_range(2047), $urandom_range(1023));
         // break the rise/fall order now and then
         if ($urandom_range(6) == 0)
            for (int k = 0; k < 3; k++) edges[s][k][11] = 1'($urandom);
      end
      il = 0;
      ir = 0;
      while (il < 3 || ir < 3) begin
         if (ir == 3 || (il < 3 && $urandom_range(1) == 0)) begin
            body.insert(body.size(), edges[0][il]);
            il++;
         end else begin
            body.insert(body.size(), edges[1][ir]);
            ir++;
         end
         if ($urandom_range(4) == 0) body.insert(body.size(), stray_word());
      end
      kind    = $urandom_range(99);
      len     = 16'(body.size());
      cut     = body.size() - 1;
      hdr_end = 1'b0;
      if (kind < 65) begin
         if ($urandom_range(1) == 0) cut = body.size();
      end else if (kind < 75) begin
         cut = $urandom_range(body.size() - 1);
      end else if (kind < 85) begin
         len = 16'($urandom_range(body.size() - 1, 1));
         cut = body.size();
      end else if (kind < 90) begin
         len = len + 16'($urandom_range(5, 1));
         cut = body.size();
      end else if (kind < 95) begin
         hdr_end = 1'b1;
         cut = body.size();
      end else begin
         len = 16'd0;
         cut = body.size();
      end
      offer({len, cfg_now.header_tag}, hdr_end);
      for (int i = 0; i < body.size(); i++) offer(body[i], i == cut);
   endtask

   task automatic queue_random(input int n);
      int goal;
      goal = words_queued + n;
      while (words_queued < goal) begin
         queue_block();
         if ($urandom_range(2) == 0) offer(stray_word(), 1'($urandom));
      end
      // close whatever block is still open before the next setting
      offer(stray_word(), 1'b1);
   endtask

   initial begin : run_phases
      logic [23:0] min_ps;
      cfg_now.header_tag    = tdcth_pkg::TAG_RESET;
      cfg_now.left_channel  = tdcth_pkg::LEFT_RESET;
      cfg_now.right_channel = tdcth_pkg::RIGHT_RESET;
      cfg_now.min_value     = tdcth_pkg::MIN_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed words on the reset settings
      begin_phase(1'b1, 1'b1);
      offer(32'h1234_5678, 1'b1);            // subevent end while seeking
      offer(32'h0000_BEEF, 1'b0);            // zero-length block
      offer(32'h0006_BEEF, 1'b0);
      offer(time_word(7'd2, 1'b1, 1, 0), 1'b0);
      offer(time_word(7'd2, 1'b0, 2047, 31), 1'b0);
      offer(time_word(7'd2, 1'b1, 4, 500), 1'b0);
      offer(time_word(7'd18, 1'b1, 10, 32), 1'b0);
      offer(time_word(7'd18, 1'b0, 20, 0), 1'b0);
      offer(time_word(7'd18, 1'b1, 30, 40), 1'b0);
      // negative rising time, untracked channel, epoch
      offer(32'h0004_BEEF, 1'b0);
      offer(time_word(7'd2, 1'b1, 0, 1023), 1'b0);
      offer(time_word(7'd2, 1'b0, 5, 0), 1'b0);
      offer(time_word(7'd5, 1'b1, 7, 7), 1'b0);
      offer(32'h6000_0000, 1'b0);
      // header lookalikes inside a block
      offer(32'h0002_BEEF, 1'b0);
      offer(32'h0000_BEEF, 1'b0);
      offer(32'h0003_BEEF, 1'b0);
      // longest block, closed by subevent end
      offer(32'hFFFF_BEEF, 1'b0);
      offer(time_word(7'd2, 1'b1, 100, 0), 1'b0);
      offer(time_word(7'd2, 1'b0, 300, 1023), 1'b0);
      offer(time_word(7'd2, 1'b1, 2047, 0), 1'b0);
      offer(time_word(7'd18, 1'b1, 1, 31), 1'b0);
      offer(time_word(7'd18, 1'b0, 2047, 1023), 1'b0);
      offer(time_word(7'd18, 1'b1, 500, 200), 1'b1);
      offer(32'h0005_BEEF, 1'b1);            // header that is also the last word
      settle();

      set_config(16'h0000, 7'd0, 7'd127, 24'd0);
      begin_phase(1'b1, 1'b1);
      queue_random(150);
      settle();

      set_config(16'hFFFF, 7'd127, 7'd0, 24'hFFFFFF);
      begin_phase(1'b1, 1'b0);
      queue_random(100);
      settle();

      // one channel read as both sides
      set_config(16'h5A5A, 7'd37, 7'd37, 24'd500);
      begin_phase(1'b0, 1'b1);
      offer(32'h0003_5A5A, 1'b0);
      offer(time_word(7'd37, 1'b1, 10, 0), 1'b0);
      offer(time_word(7'd37, 1'b0, 50, 600), 1'b0);
      offer(time_word(7'd37, 1'b1, 60, 90), 1'b0);
      queue_random(100);
      settle();

      // hold the receiver off while words keep coming
      set_config(16'($urandom), 7'($urandom), 7'($urandom), 24'($urandom_range(20000)));
      begin_phase(1'b0, 1'b0);
      hold_asked <= hold_asked + 1;
      queue_random(150);
      settle();

      for (int p = 0; p < 6; p++) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: min_ps = 24'($urandom_range(20000));
            5, 6, 7, 8:    min_ps = 24'($urandom_range(300000));
            default:       min_ps = 24'($urandom);
         endcase
         set_config(16'($urandom), 7'($urandom), 7'($urandom), min_ps);
         if (p == 0) begin_phase(1'b1, 1'b1);
         else begin_phase(1'($urandom), 1'($urandom));
         queue_random(130);
         settle();
      end

      $display("%0d words in %0d blocks under %0d register settings, %0d hits checked",
               words_taken, blocks_closed, settings_applied + 1, hits_seen);
      $display("receiver stalls included one hold of %0d cycles; %0d mismatches",
               LONG_HOLD, mismatches);
      if (mismatches == 0 && hits_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
